>>> rtl/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, key codes and the set-1 scan code to ASCII tables.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    localparam int unsigned CODE_W  = 7;
    localparam int unsigned ASCII_W = 7;
    localparam int unsigned MASK_W  = 16;
    localparam int unsigned TBL_LEN = 84;

    localparam logic [CODE_W-1:0] KEY_CTRL   = 7'h1D;
    localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
    localparam logic [CODE_W-1:0] KEY_ALT    = 7'h38;
    localparam logic [CODE_W-1:0] KEY_CAPS   = 7'h3A;
    localparam logic [CODE_W-1:0] KEY_NUM    = 7'h45;

    localparam logic [MASK_W-1:0] MASK_VALUE = 16'hFFFF;

    typedef struct packed {
        logic shift_held;
        logic caps_on;
        logic num_on;
        logic ctrl_alt_held;
    } mod_state_t;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   key_code;
        logic [ASCII_W-1:0]  ascii_char;
        logic [MASK_W-1:0]   masked_value;
    } record_t;

    localparam logic [7:0] ASCII_TBL [4][TBL_LEN] = '{
        '{8'h00,8'h1B,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,
          8'h2D,8'h3D,8'h08,8'h09,8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,
          8'h6F,8'h70,8'h5B,8'h5D,8'h0D,8'h00,8'h61,8'h73,8'h64,8'h66,8'h67,8'h68,
          8'h6A,8'h6B,8'h6C,8'h3B,8'h27,8'h60,8'h00,8'h5C,8'h7A,8'h78,8'h63,8'h76,
          8'h62,8'h6E,8'h6D,8'h2C,8'h2E,8'h2F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,
          8'h38,8'h39,8'h2D,8'h34,8'h35,8'h36,8'h2B,8'h31,8'h32,8'h33,8'h30,8'h2E},
        '{8'h00,8'h1B,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,
          8'h2D,8'h3D,8'h08,8'h09,8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,
          8'h4F,8'h50,8'h5B,8'h5D,8'h0D,8'h00,8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,
          8'h4A,8'h4B,8'h4C,8'h3B,8'h27,8'h60,8'h00,8'h5C,8'h5A,8'h58,8'h43,8'h56,
          8'h42,8'h4E,8'h4D,8'h2C,8'h2E,8'h2F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,
          8'h38,8'h39,8'h2D,8'h34,8'h35,8'h36,8'h2B,8'h31,8'h32,8'h33,8'h30,8'h2E},
        '{8'h00,8'h1B,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,8'h29,
          8'h5F,8'h2B,8'h08,8'h09,8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,
          8'h4F,8'h50,8'h7B,8'h7D,8'h0D,8'h00,8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,
          8'h4A,8'h4B,8'h4C,8'h3A,8'h22,8'h7E,8'h00,8'h7C,8'h5A,8'h58,8'h43,8'h56,
          8'h42,8'h4E,8'h4D,8'h3C,8'h3E,8'h3F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,
          8'h38,8'h39,8'h2D,8'h34,8'h35,8'h36,8'h2B,8'h31,8'h32,8'h33,8'h30,8'h2E},
        '{8'h00,8'h1B,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5E,8'h26,8'h2A,8'h28,8'h29,
          8'h5F,8'h2B,8'h08,8'h09,8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,
          8'h6F,8'h70,8'h7B,8'h7D,8'h0D,8'h00,8'h61,8'h73,8'h64,8'h66,8'h67,8'h68,
          8'h6A,8'h6B,8'h6C,8'h3A,8'h22,8'h7E,8'h00,8'h7C,8'h7A,8'h78,8'h63,8'h76,
          8'h62,8'h6E,8'h6D,8'h3C,8'h3E,8'h3F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,
          8'h38,8'h39,8'h2D,8'h34,8'h35,8'h36,8'h2B,8'h31,8'h32,8'h33,8'h30,8'h2E}
    };

    function automatic logic is_recordable(input logic [CODE_W-1:0] code);
        return ((code >= 7'h10) && (code <= 7'h19)) ||
               ((code >= 7'h1E) && (code <= 7'h26)) ||
               ((code >= 7'h2C) && (code <= 7'h32)) ||
               ((code >= 7'h02) && (code <= 7'h0B));
    endfunction

    function automatic logic [ASCII_W-1:0] lookup_ascii(input logic [1:0] sel,
                                                        input logic [CODE_W-1:0] code);
        logic [7:0] entry;
        entry = 8'h00;
        if (code < CODE_W'(TBL_LEN)) begin
            entry = ASCII_TBL[sel][code];
        end
        return entry[ASCII_W-1:0];
    endfunction

endpackage

>>> rtl/sc2a_modifiers.sv
// ----------------------------------------------------------------------------
// sc2a_modifiers
// Holds the shift, caps lock, num lock and ctrl/alt marks and computes their
// values after the current key event.
// ----------------------------------------------------------------------------
module sc2a_modifiers (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [sc2a_pkg::CODE_W-1:0] code,
    input  logic                        released,
    output sc2a_pkg::mod_state_t        mods_next
);

    sc2a_pkg::mod_state_t mods_reg;

    always_comb begin
        mods_next = mods_reg;
        if (released) begin
            if (code == sc2a_pkg::KEY_CAPS) begin
                mods_next.caps_on = ~mods_reg.caps_on;
            end else if (code == sc2a_pkg::KEY_LSHIFT || code == sc2a_pkg::KEY_RSHIFT) begin
                mods_next.shift_held = 1'b0;
            end else if (code == sc2a_pkg::KEY_NUM) begin
                mods_next.num_on = ~mods_reg.num_on;
            end
            if (code == sc2a_pkg::KEY_CTRL || code == sc2a_pkg::KEY_ALT) begin
                mods_next.ctrl_alt_held = 1'b0;
            end
        end else begin
            if (code == sc2a_pkg::KEY_LSHIFT || code == sc2a_pkg::KEY_RSHIFT) begin
                mods_next.shift_held = 1'b1;
            end
            if (code == sc2a_pkg::KEY_CTRL || code == sc2a_pkg::KEY_ALT) begin
                mods_next.ctrl_alt_held = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mods_reg.shift_held    <= 1'b0;
            mods_reg.caps_on       <= 1'b0;
            mods_reg.num_on        <= 1'b1;
            mods_reg.ctrl_alt_held <= 1'b0;
        end else if (step) begin
            mods_reg <= mods_next;
        end
    end

endmodule

>>> rtl/sc2a_lookup.sv
// ----------------------------------------------------------------------------
// sc2a_lookup
// Decides whether a key event is recorded and builds the record from the
// ASCII table chosen by the shift and caps marks.
// ----------------------------------------------------------------------------
module sc2a_lookup (
    input  logic                        enable,
    input  logic [sc2a_pkg::CODE_W-1:0] code,
    input  logic                        released,
    input  sc2a_pkg::mod_state_t        mods,
    output sc2a_pkg::record_t           record
);

    logic                         hit;
    logic [sc2a_pkg::ASCII_W-1:0] ascii;

    assign hit   = enable && released && !mods.ctrl_alt_held &&
                   sc2a_pkg::is_recordable(code);
    assign ascii = sc2a_pkg::lookup_ascii({mods.shift_held, mods.caps_on}, code);

    always_comb begin
        record = '0;
        if (hit) begin
            record.valid        = 1'b1;
            record.key_code     = code;
            record.ascii_char   = ascii;
            record.masked_value = {{(sc2a_pkg::MASK_W - sc2a_pkg::ASCII_W){1'b0}}, ascii}
                                  ^ sc2a_pkg::MASK_VALUE;
        end
    end

endmodule

>>> rtl/scan_code_to_ascii_with_modifiers_top.sv
// ----------------------------------------------------------------------------
// scan_code_to_ascii_with_modifiers_top
// Set-1 scan code to ASCII converter with modifier tracking and key records.
// ----------------------------------------------------------------------------
// Key events enter on the s_axis channel: the make code in tdata, the
// release flag in tuser. Every accepted event yields exactly one transfer on
// the m_axis channel; tuser is high when the event is a recorded key, and
// tdata then holds the code, its ASCII and the ASCII inverted to 16 bits.
// Unrecorded events give an all-zero transfer.
// The event is captured in an input register, the modifier update and the
// table lookup run combinationally, and the result sits in an output
// register; one event is taken every cycle while the receiver does not stall.
// Modifier state advances in event order as each event moves to the output
// register. When the receiver stalls, the output register holds its
// transfer, the input register holds the next event and s_axis_tready
// drops only when both are full.
// cfg_we writes cfg_wdata to the enable bit; with enable low no modifier
// state changes and nothing is recorded. Write it only while the block is idle.
// Reset empties both registers, clears enable, shift, caps and ctrl/alt and
// sets num lock.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_with_modifiers_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [6:0] scan_code, [7] zero
    input  logic        s_axis_tuser,  // [0] released
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [6:0] key_code, [13:7] ascii_char,
                                       // [29:14] masked_value, [31:30] zero
    output logic        m_axis_tuser   // [0] record_valid
);

    logic                        enable_reg;
    logic                        in_valid_reg;
    logic [sc2a_pkg::CODE_W-1:0] in_code_reg;
    logic                        in_rel_reg;
    logic                        out_valid_reg;
    sc2a_pkg::record_t           out_rec_reg;
    logic                        out_load;
    logic                        advance;
    sc2a_pkg::mod_state_t        mods_next;
    sc2a_pkg::record_t           rec_next;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || out_load;

    sc2a_modifiers u_modifiers (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance && enable_reg),
        .code      (in_code_reg),
        .released  (in_rel_reg),
        .mods_next (mods_next)
    );

    sc2a_lookup u_lookup (
        .enable   (enable_reg),
        .code     (in_code_reg),
        .released (in_rel_reg),
        .mods     (mods_next),
        .record   (rec_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_code_reg <= s_axis_tdata[sc2a_pkg::CODE_W-1:0];
            in_rel_reg  <= s_axis_tuser;
        end
        if (advance) begin
            out_rec_reg <= rec_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rec_reg.valid;
    assign m_axis_tdata  = {2'b00, out_rec_reg.masked_value,
                            out_rec_reg.ascii_char, out_rec_reg.key_code};

endmodule
